// ----- hdl/box_overlap_ratio_macros.svh -----
// Assertion macros shared by the box overlap ratio block.
`ifndef BOX_OVERLAP_RATIO_MACROS_SVH
`define BOX_OVERLAP_RATIO_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define BOR_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define BOR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bor_pkg.sv -----
// Shared constants and pipeline control type of the box overlap ratio block.
`default_nettype none

package bor_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 16;

  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_TRUTH = 1'b1;

  // Control that travels with every pipeline stage.
  typedef struct packed {
    logic valid;
    logic bad;
  } bor_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/bor_geom.sv -----
// Three-stage geometry front end: intersection, areas and the divisor.
`default_nettype none

module bor_geom #(
  parameter int COORD_BITS = bor_pkg::COORD_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          mode,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [COORD_BITS-1:0]        anchor_left,
  input  wire  [COORD_BITS-1:0]        anchor_top,
  input  wire  [COORD_BITS-1:0]        anchor_right,
  input  wire  [COORD_BITS-1:0]        anchor_bottom,
  input  wire  [COORD_BITS-1:0]        truth_left,
  input  wire  [COORD_BITS-1:0]        truth_top,
  input  wire  [COORD_BITS-1:0]        truth_right,
  input  wire  [COORD_BITS-1:0]        truth_bottom,
  output bor_pkg::bor_ctl_t            out_ctl,
  input  wire                          out_ready,
  output logic [2*COORD_BITS+1:0]      out_num,
  output logic [2*COORD_BITS+1:0]      out_den
);

  localparam int LW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  bor_pkg::bor_ctl_t s1_ctl_r, s1_ctl_nxt;
  bor_pkg::bor_ctl_t s2_ctl_r;
  bor_pkg::bor_ctl_t s3_ctl_r;
  logic s1_adv, s2_adv, s3_adv;

  logic [COORD_BITS-1:0] ix0, iy0, ix1, iy1;
  logic [LW-1:0] iw_nxt, ih_nxt, aw_nxt, ah_nxt, tw_nxt, th_nxt;
  logic [LW-1:0] iw_r, ih_r, aw_r, ah_r, tw_r, th_r;
  logic [PW-1:0] inter_nxt, area_a_nxt, area_t_nxt;
  logic [PW-1:0] inter_r, area_a_r, area_t_r;
  logic [PW-1:0] num_r, den_r, den_nxt;

  // A stage moves on when it is empty or the next one moves on.
  assign s3_adv   = !s3_ctl_r.valid || out_ready;
  assign s2_adv   = !s2_ctl_r.valid || s3_adv;
  assign s1_adv   = !s1_ctl_r.valid || s2_adv;
  assign in_ready = s1_adv;

  always_comb begin
    ix0 = (anchor_left   > truth_left)   ? anchor_left   : truth_left;
    iy0 = (anchor_top    > truth_top)    ? anchor_top    : truth_top;
    ix1 = (anchor_right  < truth_right)  ? anchor_right  : truth_right;
    iy1 = (anchor_bottom < truth_bottom) ? anchor_bottom : truth_bottom;
    iw_nxt = (ix1 >= ix0) ? ({1'b0, ix1} - {1'b0, ix0} + LW'(1)) : '0;
    ih_nxt = (iy1 >= iy0) ? ({1'b0, iy1} - {1'b0, iy0} + LW'(1)) : '0;
    aw_nxt = {1'b0, anchor_right}  - {1'b0, anchor_left}  + LW'(1);
    ah_nxt = {1'b0, anchor_bottom} - {1'b0, anchor_top}   + LW'(1);
    tw_nxt = {1'b0, truth_right}   - {1'b0, truth_left}   + LW'(1);
    th_nxt = {1'b0, truth_bottom}  - {1'b0, truth_top}    + LW'(1);
    s1_ctl_nxt.valid = in_valid;
    s1_ctl_nxt.bad   = (anchor_right < anchor_left) || (anchor_bottom < anchor_top) ||
                       (truth_right < truth_left) || (truth_bottom < truth_top);
  end

  always_comb begin
    inter_nxt  = PW'(iw_r) * PW'(ih_r);
    area_a_nxt = PW'(aw_r) * PW'(ah_r);
    area_t_nxt = PW'(tw_r) * PW'(th_r);
  end

  // The union never exceeds the sum of the areas, so the modular sum is exact.
  always_comb begin
    unique case (mode)
      bor_pkg::MODE_TRUTH: den_nxt = area_t_r;
      default:             den_nxt = area_a_r + area_t_r - inter_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      if (s1_adv) s1_ctl_r <= s1_ctl_nxt;
      if (s2_adv) s2_ctl_r <= s1_ctl_r;
      if (s3_adv) s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      iw_r <= iw_nxt;
      ih_r <= ih_nxt;
      aw_r <= aw_nxt;
      ah_r <= ah_nxt;
      tw_r <= tw_nxt;
      th_r <= th_nxt;
    end
    if (s2_adv && s1_ctl_r.valid) begin
      inter_r  <= inter_nxt;
      area_a_r <= area_a_nxt;
      area_t_r <= area_t_nxt;
    end
    if (s3_adv && s2_ctl_r.valid) begin
      num_r <= inter_r;
      den_r <= den_nxt;
    end
  end

  assign out_ctl = s3_ctl_r;
  assign out_num = num_r;
  assign out_den = den_r;

endmodule

`default_nettype wire

// ----- hdl/bor_div_step.sv -----
// One registered step of the restoring fixed-point divider.
`default_nettype none

module bor_div_step #(
  parameter int PW = 2 * bor_pkg::COORD_BITS + 2,
  parameter int QW = bor_pkg::FRACTION_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  bor_pkg::bor_ctl_t  in_ctl,
  output logic               in_ready,
  input  wire  [PW-1:0]      in_t,
  input  wire  [PW-1:0]      in_den,
  input  wire  [QW-1:0]      in_q,
  output bor_pkg::bor_ctl_t  out_ctl,
  input  wire                out_ready,
  output logic [PW-1:0]      out_t,
  output logic [PW-1:0]      out_den,
  output logic [QW-1:0]      out_q
);

  bor_pkg::bor_ctl_t ctl_r;
  logic [PW-1:0] t_r, t_nxt, den_r, rem;
  logic [QW-1:0] q_r, q_nxt;
  logic ge, adv;

  assign adv      = !ctl_r.valid || out_ready;
  assign in_ready = adv;

  // The partial remainder stays below the divisor, so doubling it cannot overflow.
  always_comb begin
    ge    = (in_t >= in_den);
    rem   = ge ? (in_t - in_den) : in_t;
    t_nxt = {rem[PW-2:0], 1'b0};
    q_nxt = {in_q[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ctl.valid) begin
      t_r   <= t_nxt;
      den_r <= in_den;
      q_r   <= q_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign out_t   = t_r;
  assign out_den = den_r;
  assign out_q   = q_r;

endmodule

`default_nettype wire

// ----- hdl/bor_divider.sv -----
// Pipelined divider: a chain of one-bit steps, one quotient bit per stage.
`default_nettype none

module bor_divider #(
  parameter int PW = 2 * bor_pkg::COORD_BITS + 2,
  parameter int QW = bor_pkg::FRACTION_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  bor_pkg::bor_ctl_t  in_ctl,
  output logic               in_ready,
  input  wire  [PW-1:0]      in_num,
  input  wire  [PW-1:0]      in_den,
  output bor_pkg::bor_ctl_t  out_ctl,
  input  wire                out_ready,
  output logic [PW-1:0]      out_t,
  output logic [PW-1:0]      out_den,
  output logic [QW-1:0]      out_q
);

  bor_pkg::bor_ctl_t ctl_c [QW+1];
  logic              rdy_c [QW+1];
  logic [PW-1:0]     t_c   [QW+1];
  logic [PW-1:0]     den_c [QW+1];
  logic [QW-1:0]     q_c   [QW+1];

  assign ctl_c[0]   = in_ctl;
  assign t_c[0]     = in_num;
  assign den_c[0]   = in_den;
  assign q_c[0]     = '0;
  assign in_ready   = rdy_c[0];
  assign rdy_c[QW]  = out_ready;

  for (genvar i = 0; i < QW; i++) begin : g_step
    bor_div_step #(
      .PW (PW),
      .QW (QW)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_ctl    (ctl_c[i]),
      .in_ready  (rdy_c[i]),
      .in_t      (t_c[i]),
      .in_den    (den_c[i]),
      .in_q      (q_c[i]),
      .out_ctl   (ctl_c[i+1]),
      .out_ready (rdy_c[i+1]),
      .out_t     (t_c[i+1]),
      .out_den   (den_c[i+1]),
      .out_q     (q_c[i+1])
    );
  end

  assign out_ctl = ctl_c[QW];
  assign out_t   = t_c[QW];
  assign out_den = den_c[QW];
  assign out_q   = q_c[QW];

endmodule

`default_nettype wire

// ----- hdl/box_overlap_ratio.sv -----
// Box overlap ratio: intersection over union or over truth area, one box pair per request.
//
// The input channel carries one anchor box and one ground-truth box per request,
// eight inclusive pixel coordinates packed in in_tdata. The result channel returns
// the ratio in out_tdata as unsigned fixed point (1 << FRACTION_BITS is 1.0,
// truncated) and a malformed-box flag in out_tuser; a malformed pair scores zero.
// cfg_wr_en and cfg_wr_data set the ratio mode: 0 divides by the union, 1 by the
// ground-truth area. Write it only while no request is in flight.
// The path runs through three geometry stages, one divider stage per fraction bit
// and the output register, which also resolves the last quotient bit. One request
// is accepted every cycle unless a stalled receiver has filled every stage.
// Each stage holds its item while the next one is full and held, so a stalled receiver
// first fills the empty stages; in_tready falls only when every stage is full.
// Nothing is lost or repeated under stall.
// A synchronous active-low reset empties the pipeline and selects union mode.
`default_nettype none

module box_overlap_ratio #(
  parameter int COORD_BITS    = bor_pkg::COORD_BITS,
  parameter int FRACTION_BITS = bor_pkg::FRACTION_BITS
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       cfg_wr_en,
  input  wire                                       cfg_wr_data,
  input  wire                                       in_tvalid,
  output logic                                      in_tready,
  // anchor_left, anchor_top, anchor_right, anchor_bottom,
  // truth_left, truth_top, truth_right, truth_bottom
  input  wire  [((8*COORD_BITS+7)/8)*8-1:0]         in_tdata,
  output logic                                      out_tvalid,
  input  wire                                       out_tready,
  // overlap_score
  output logic [((FRACTION_BITS+1+7)/8)*8-1:0]      out_tdata,
  // bad_box
  output logic [0:0]                                out_tuser
);

`include "box_overlap_ratio_macros.svh"

  localparam int PW    = 2 * COORD_BITS + 2;
  localparam int SW    = FRACTION_BITS + 1;
  localparam int OUT_W = ((SW + 7) / 8) * 8;

  logic mode_r, mode_nxt;

  bor_pkg::bor_ctl_t geom_ctl, div_ctl;
  logic geom_ready, div_ready, out_adv;
  logic [PW-1:0] geom_num, geom_den, div_t, div_den;
  logic [FRACTION_BITS-1:0] div_q;

  logic          out_valid_r;
  logic          bad_r;
  logic [SW-1:0] score_r, score_nxt;

  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bor_pkg::MODE_UNION;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  bor_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .in_valid      (in_tvalid),
    .in_ready      (geom_ready),
    .anchor_left   (in_tdata[0*COORD_BITS +: COORD_BITS]),
    .anchor_top    (in_tdata[1*COORD_BITS +: COORD_BITS]),
    .anchor_right  (in_tdata[2*COORD_BITS +: COORD_BITS]),
    .anchor_bottom (in_tdata[3*COORD_BITS +: COORD_BITS]),
    .truth_left    (in_tdata[4*COORD_BITS +: COORD_BITS]),
    .truth_top     (in_tdata[5*COORD_BITS +: COORD_BITS]),
    .truth_right   (in_tdata[6*COORD_BITS +: COORD_BITS]),
    .truth_bottom  (in_tdata[7*COORD_BITS +: COORD_BITS]),
    .out_ctl       (geom_ctl),
    .out_ready     (div_ready),
    .out_num       (geom_num),
    .out_den       (geom_den)
  );

  bor_divider #(
    .PW (PW),
    .QW (FRACTION_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (geom_ctl),
    .in_ready  (div_ready),
    .in_num    (geom_num),
    .in_den    (geom_den),
    .out_ctl   (div_ctl),
    .out_ready (out_adv),
    .out_t     (div_t),
    .out_den   (div_den),
    .out_q     (div_q)
  );

  assign in_tready = geom_ready;
  assign out_adv   = !out_valid_r || out_tready;

  // The final compare yields the least significant quotient bit.
  assign score_nxt = div_ctl.bad ? '0 : {div_q, (div_t >= div_den)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && div_ctl.valid) begin
      score_r <= score_nxt;
      bad_r   <= div_ctl.bad;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_W'(score_r);
  assign out_tuser[0] = bad_r;

  `BOR_ASSERT_IMPLY(a_score_le_one, clk, rst_n, out_tvalid, score_r <= (SW'(1) << FRACTION_BITS), "overlap score above 1.0")
  `BOR_ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_tvalid && bad_r, score_r == '0, "malformed box with nonzero score")
  `BOR_ASSERT_IMPLY(a_ready_only_full, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled while the output drains")
  `BOR_ASSERT_NEXT(a_drain_moves, clk, rst_n, out_tvalid && out_tready && !div_ctl.valid, !out_tvalid, "taken result was repeated")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking stream testbench for the box overlap ratio block.
`default_nettype none

typedef struct packed {
  logic [bor_pkg::COORD_BITS-1:0] truth_bottom;
  logic [bor_pkg::COORD_BITS-1:0] truth_right;
  logic [bor_pkg::COORD_BITS-1:0] truth_top;
  logic [bor_pkg::COORD_BITS-1:0] truth_left;
  logic [bor_pkg::COORD_BITS-1:0] anchor_bottom;
  logic [bor_pkg::COORD_BITS-1:0] anchor_right;
  logic [bor_pkg::COORD_BITS-1:0] anchor_top;
  logic [bor_pkg::COORD_BITS-1:0] anchor_left;
} box_pair_t;

typedef struct {
  logic [bor_pkg::FRACTION_BITS:0] score;
  logic                            bad;
} overlap_result_t;

class overlap_tracker;
  logic            ratio_mode;
  overlap_result_t pending_scores[$];
  int              mismatch_count;

  function new();
    ratio_mode     = bor_pkg::MODE_UNION;
    mismatch_count = 0;
  endfunction

  task report(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function int pending();
    return pending_scores.size();
  endfunction

  // Exact quotient, scaled by 2^FRACTION_BITS and truncated.
  function overlap_result_t predict_overlap(box_pair_t p);
    longint unsigned lo_x, lo_y, hi_x, hi_y, iw, ih, inter, area_a, area_t, den, quot;
    overlap_result_t r;
    r.bad = (p.anchor_right < p.anchor_left) || (p.anchor_bottom < p.anchor_top) ||
            (p.truth_right < p.truth_left) || (p.truth_bottom < p.truth_top);
    r.score = '0;
    if (!r.bad) begin
      lo_x = 64'((p.anchor_left > p.truth_left) ? p.anchor_left : p.truth_left);
      lo_y = 64'((p.anchor_top > p.truth_top) ? p.anchor_top : p.truth_top);
      hi_x = 64'((p.anchor_right < p.truth_right) ? p.anchor_right : p.truth_right);
      hi_y = 64'((p.anchor_bottom < p.truth_bottom) ? p.anchor_bottom : p.truth_bottom);
      iw = (hi_x >= lo_x) ? hi_x - lo_x + 1 : 0;
      ih = (hi_y >= lo_y) ? hi_y - lo_y + 1 : 0;
      inter  = iw * ih;
      area_a = (longint'(p.anchor_right) - p.anchor_left + 1) *
               (longint'(p.anchor_bottom) - p.anchor_top + 1);
      area_t = (longint'(p.truth_right) - p.truth_left + 1) *
               (longint'(p.truth_bottom) - p.truth_top + 1);
      den = (ratio_mode == bor_pkg::MODE_UNION) ? area_a + area_t - inter : area_t;
      quot = (inter << bor_pkg::FRACTION_BITS) / den;
      r.score = quot[bor_pkg::FRACTION_BITS:0];
    end
    return r;
  endfunction

  function void note_pair(box_pair_t p);
    pending_scores.push_back(predict_overlap(p));
  endfunction

  task check_score(logic [23:0] tdata, logic [0:0] tuser);
    overlap_result_t want;
    if (pending_scores.size() == 0) begin
      report($sformatf("result %h/%b with nothing outstanding", tdata, tuser));
    end else begin
      want = pending_scores.pop_front();
      if (tdata[bor_pkg::FRACTION_BITS:0] !== want.score)
        report($sformatf("overlap_score %0d, want %0d",
                         tdata[bor_pkg::FRACTION_BITS:0], want.score));
      if (tdata[23:bor_pkg::FRACTION_BITS+1] !== '0)
        report($sformatf("out_tdata padding %h not zero", tdata));
      if (tuser[0] !== want.bad)
        report($sformatf("bad_box %b, want %b", tuser[0], want.bad));
    end
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = ((8*bor_pkg::COORD_BITS+7)/8)*8;
  localparam int OUT_W = ((bor_pkg::FRACTION_BITS+1+7)/8)*8;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_wr_data = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0]       out_tuser;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  overlap_tracker tracker = new();

  box_overlap_ratio u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Requests are noted before results are checked, so ordering within an edge is fixed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_pair(box_pair_t'(in_tdata));
      if (out_tvalid && out_tready) tracker.check_score(out_tdata, out_tuser);
    end
  end

  function automatic box_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int tx0, int ty0, int tx1, int ty1);
    box_pair_t p;
    p.anchor_left  = 16'(ax0);
    p.anchor_top   = 16'(ay0);
    p.anchor_right = 16'(ax1);
    p.anchor_bottom = 16'(ay1);
    p.truth_left   = 16'(tx0);
    p.truth_top    = 16'(ty0);
    p.truth_right  = 16'(tx1);
    p.truth_bottom = 16'(ty1);
    return p;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Returns {right, left} with right < left, starting from a well-formed span.
  function automatic logic [31:0] broken_span(logic [15:0] lo, logic [15:0] hi);
    if (lo != hi) return {lo, hi};
    if (lo != 16'hFFFF) return {lo, lo + 16'd1};
    return {16'hFFFE, 16'hFFFF};
  endfunction

  function automatic box_pair_t random_pair();
    int kind, span, w, h, tw, th, ax, ay, tx, ty;
    box_pair_t p;
    kind = $urandom_range(99);
    if (kind < 10) begin
      p = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      case ($urandom_range(3))
        0:       span = 3;
        1:       span = 63;
        2:       span = 4095;
        default: span = 65535;
      endcase
      w  = $urandom_range(span);
      h  = $urandom_range(span);
      tw = $urandom_range(span);
      th = $urandom_range(span);
      ax = $urandom_range(65535 - w);
      ay = $urandom_range(65535 - h);
      // Place the truth box near the anchor so that most pairs overlap.
      tx = clamp(ax + $urandom_range(2 * span) - span, 0, 65535 - tw);
      ty = clamp(ay + $urandom_range(2 * span) - span, 0, 65535 - th);
      p = make_pair(ax, ay, ax + w, ay + h, tx, ty, tx + tw, ty + th);
      if (kind < 20) begin
        case ($urandom_range(3))
          0: {p.anchor_right, p.anchor_left} = broken_span(p.anchor_left, p.anchor_right);
          1: {p.anchor_bottom, p.anchor_top} = broken_span(p.anchor_top, p.anchor_bottom);
          2: {p.truth_right, p.truth_left} = broken_span(p.truth_left, p.truth_right);
          default: {p.truth_bottom, p.truth_top} = broken_span(p.truth_top, p.truth_bottom);
        endcase
      end
    end
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = p;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_mode(logic mode);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    tracker.ratio_mode = mode;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_directed();
    send_pair(make_pair(0, 0, 65535, 65535, 0, 0, 65535, 65535));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 9, 9, 20, 20, 29, 29));
    send_pair(make_pair(5, 0, 4, 10, 0, 0, 10, 10));
    send_pair(make_pair(0, 65535, 10, 0, 0, 0, 10, 10));
    send_pair(make_pair(0, 0, 10, 10, 65535, 0, 0, 10));
    send_pair(make_pair(0, 0, 10, 10, 0, 7, 10, 6));
    send_pair(make_pair(0, 0, 65535, 65535, 100, 100, 199, 199));
    send_pair(make_pair(0, 0, 10, 10, 10, 10, 20, 20));
    send_pair(make_pair(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
    send_pair(make_pair(3, 5, 40, 33, 17, 2, 61, 29));
    send_pair(make_pair(65535, 65535, 65535, 65535, 0, 0, 0, 0));
  endtask

  initial begin
    int phase;
    int n;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    write_mode(bor_pkg::MODE_UNION);
    run_directed();
    write_mode(bor_pkg::MODE_TRUTH);
    run_directed();

    // Each idle pattern runs once in each ratio mode.
    for (phase = 0; phase < 8; phase++) begin
      write_mode((phase % 2) ? bor_pkg::MODE_TRUTH : bor_pkg::MODE_UNION);
      case (phase / 2)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (n = 0; n < 100; n++) send_pair(random_pair());
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    repeat (30) @(negedge clk);
    for (n = tracker.pending(); n > 0; n--)
      tracker.report("expected result never arrived");

    if (tracker.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/bor_pkg.sv
hdl/bor_geom.sv
hdl/bor_div_step.sv
hdl/bor_divider.sv
hdl/box_overlap_ratio.sv
tb/tb_top.sv
